// ===== rtl/u8n1f_pkg.sv =====
package u8n1f_pkg;

	// Item opcodes
	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_PUSH = 2'd1,
		OP_POP  = 2'd2,
		OP_NOP  = 2'd3
	} op_t;

	localparam int COUNT_W = 6;

	typedef struct packed {
		op_t        op;
		logic [7:0] tx_byte;
		logic       rx_level;
	} item_t;

	typedef struct packed {
		logic               tx_line;
		logic [7:0]         rx_data;
		logic               rx_data_valid;
		logic [COUNT_W-1:0] rx_count;
		logic [COUNT_W-1:0] tx_count;
		logic               push_accepted;
		logic               rx_dropped;
	} result_t;

	// Ring FIFO control and status
	typedef struct packed {
		logic push;
		logic pop;
	} ring_ctl_t;

	typedef struct packed {
		logic               full;
		logic               empty;
		logic [COUNT_W-1:0] count;
	} ring_stat_t;

endpackage

// ===== rtl/u8n1f_chan.sv =====
interface u8n1f_chan #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/uart_8n1_with_fifos_core.sv =====
// Channel   Direction  Payload
// item      sink       op, tx_byte, rx_level
// result    source     tx_line, rx_data, rx_data_valid, rx_count, tx_count,
//                      push_accepted, rx_dropped
// cfg       write      cfg_wr_en, cfg_wr_data (ticks_per_bit)
//
// One item per clock while the result is taken: an item waits in the input register, then its
// counter and pointer updates land in the state and result registers.
// Reset is asynchronous, active low; ticks_per_bit resets to 208, line high.
// A stalled result holds the input register; the next item waits there.
module uart_8n1_with_fifos_core #(
	parameter int FIFO_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	u8n1f_chan.sink     item,
	u8n1f_chan.source   result,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data
);
	import u8n1f_pkg::*;

	localparam logic [15:0] TICKS_RESET = 16'd208;
	localparam logic [3:0]  FRAME_BITS  = 4'd9;
	localparam logic [3:0]  DATA_BITS   = 4'd8;

	// Input stage
	logic  valid_s1;
	item_t item_s1;
	logic  advance;

	// Result flags
	logic res_valid_q, rx_valid_q, accepted_q, dropped_q;

	// Configuration
	logic [15:0] ticks_per_bit_q;
	logic [15:0] period;

	// Transmitter state
	logic        tx_running_q, tx_running_d;
	logic [15:0] tx_tick_q, tx_tick_d;
	logic [3:0]  tx_bits_q, tx_bits_d;
	logic        tx_level_q, tx_level_d;
	logic [8:0]  tx_frame;
	logic [3:0]  tx_bit_idx;

	// Receiver state
	logic        rx_busy_q, rx_busy_d;
	logic [16:0] rx_tick_q, rx_tick_d;
	logic [3:0]  rx_taken_q, rx_taken_d;
	logic [7:0]  rx_shift_q, rx_shift_d;
	logic        rx_prev_q, rx_prev_d;

	logic rx_valid_d, accepted_d, dropped_d;

	ring_ctl_t  tx_ctl, rx_ctl;
	ring_stat_t tx_stat, rx_stat;
	logic [7:0] tx_rd, rx_rd;

	u8n1f_ring #(.DEPTH(FIFO_DEPTH)) u_tx_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (tx_ctl),
		.wr_data (item_s1.tx_byte),
		.rd_data (tx_rd),
		.stat    (tx_stat)
	);

	u8n1f_ring #(.DEPTH(FIFO_DEPTH)) u_rx_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (rx_ctl),
		.wr_data (rx_shift_q),
		.rd_data (rx_rd),
		.stat    (rx_stat)
	);

	// Handshake: process the held item when the result slot is free
	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	// Zero period acts as one
	assign period = (ticks_per_bit_q == 16'd0) ? 16'd1 : ticks_per_bit_q;

	// Frame bits after the start bit: data LSB first, then stop
	assign tx_frame   = {1'b1, tx_rd};
	assign tx_bit_idx = FRAME_BITS - tx_bits_q;

	// Next state for the item in the input register
	always_comb begin
		tx_running_d = tx_running_q;
		tx_tick_d    = tx_tick_q;
		tx_bits_d    = tx_bits_q;
		tx_level_d   = tx_level_q;
		rx_busy_d    = rx_busy_q;
		rx_tick_d    = rx_tick_q;
		rx_taken_d   = rx_taken_q;
		rx_shift_d   = rx_shift_q;
		rx_prev_d    = rx_prev_q;
		rx_valid_d   = 1'b0;
		accepted_d   = 1'b0;
		dropped_d    = 1'b0;
		tx_ctl       = '0;
		rx_ctl       = '0;

		if (advance) begin
			unique case (item_s1.op)
				OP_TICK: begin
					// Transmit bit timer
					if (tx_running_q) begin
						if (tx_tick_q > 16'd1) begin
							tx_tick_d = tx_tick_q - 16'd1;
						end else begin
							tx_tick_d = period;
							if (tx_bits_q != 4'd0) begin
								tx_level_d = tx_frame[tx_bit_idx];
								tx_bits_d  = tx_bits_q - 4'd1;
							end else if (!tx_stat.empty) begin
								tx_ctl.pop = 1'b1;
								tx_bits_d  = FRAME_BITS;
								tx_level_d = 1'b0;
							end else begin
								tx_running_d = 1'b0;
								tx_level_d   = 1'b1;
							end
						end
					end
					// Receive sampler
					if (rx_busy_q) begin
						if (rx_tick_q > 17'd1) begin
							rx_tick_d = rx_tick_q - 17'd1;
						end else begin
							rx_tick_d = {1'b0, period};
							if (rx_taken_q < DATA_BITS) begin
								rx_shift_d = {item_s1.rx_level, rx_shift_q[7:1]};
								rx_taken_d = rx_taken_q + 4'd1;
							end else begin
								if (!rx_stat.full) begin
									rx_ctl.push = 1'b1;
								end else begin
									dropped_d = 1'b1;
								end
								rx_busy_d = 1'b0;
							end
						end
					end else if (rx_prev_q && !item_s1.rx_level) begin
						rx_busy_d  = 1'b1;
						rx_tick_d  = {1'b0, period} + {2'b00, period[15:1]};
						rx_shift_d = '0;
						rx_taken_d = '0;
					end
					rx_prev_d = item_s1.rx_level;
				end
				OP_PUSH: begin
					if (!tx_stat.full) begin
						tx_ctl.push = 1'b1;
						accepted_d  = 1'b1;
						if (!tx_running_q) begin
							tx_running_d = 1'b1;
							tx_tick_d    = period;
						end
					end
				end
				OP_POP: begin
					if (!rx_stat.empty) begin
						rx_ctl.pop = 1'b1;
						rx_valid_d = 1'b1;
					end
				end
				OP_NOP: begin
				end
				default: begin
				end
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.data;
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_per_bit_q <= TICKS_RESET;
		end else if (cfg_wr_en) begin
			ticks_per_bit_q <= cfg_wr_data;
		end
	end

	// Transceiver state and result flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_running_q <= 1'b0;
			tx_tick_q    <= '0;
			tx_bits_q    <= '0;
			tx_level_q   <= 1'b1;
			rx_busy_q    <= 1'b0;
			rx_tick_q    <= '0;
			rx_taken_q   <= '0;
			rx_shift_q   <= '0;
			rx_prev_q    <= 1'b1;
			res_valid_q  <= 1'b0;
			rx_valid_q   <= 1'b0;
			accepted_q   <= 1'b0;
			dropped_q    <= 1'b0;
		end else begin
			tx_running_q <= tx_running_d;
			tx_tick_q    <= tx_tick_d;
			tx_bits_q    <= tx_bits_d;
			tx_level_q   <= tx_level_d;
			rx_busy_q    <= rx_busy_d;
			rx_tick_q    <= rx_tick_d;
			rx_taken_q   <= rx_taken_d;
			rx_shift_q   <= rx_shift_d;
			rx_prev_q    <= rx_prev_d;
			if (advance) begin
				res_valid_q <= 1'b1;
				rx_valid_q  <= rx_valid_d;
				accepted_q  <= accepted_d;
				dropped_q   <= dropped_d;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Result: state after the last processed item holds while the result waits
	assign result.valid              = res_valid_q;
	assign result.data.tx_line       = tx_level_q;
	assign result.data.rx_data       = rx_valid_q ? rx_rd : 8'd0;
	assign result.data.rx_data_valid = rx_valid_q;
	assign result.data.rx_count      = rx_stat.count;
	assign result.data.tx_count      = tx_stat.count;
	assign result.data.push_accepted = accepted_q;
	assign result.data.rx_dropped    = dropped_q;
endmodule

// ===== rtl/u8n1f_ring.sv =====
module u8n1f_ring #(
	parameter int DEPTH = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  u8n1f_pkg::ring_ctl_t   ctl,
	input  logic [7:0]             wr_data,
	output logic [7:0]             rd_data,
	output u8n1f_pkg::ring_stat_t  stat
);
	import u8n1f_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = (PW + 1 > COUNT_W) ? PW + 1 : COUNT_W;
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	logic [7:0]    mem [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW-1:0] wr_ptr_nxt, rd_ptr_nxt;
	logic [CW-1:0] fill;

	// Wrap the pointers at the ring size
	assign wr_ptr_nxt = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
	assign rd_ptr_nxt = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;

	// Fill level is (write - read) mod depth
	always_comb begin
		if (wr_ptr_q >= rd_ptr_q) begin
			fill = CW'(wr_ptr_q) - CW'(rd_ptr_q);
		end else begin
			fill = CW'(wr_ptr_q) + CW'(DEPTH) - CW'(rd_ptr_q);
		end
	end

	assign stat.full  = (wr_ptr_nxt == rd_ptr_q);
	assign stat.empty = (wr_ptr_q == rd_ptr_q);
	assign stat.count = fill[COUNT_W-1:0];

	// Storage with registered read port; read data holds until the next pop
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[wr_ptr_q] <= wr_data;
		end
		if (ctl.pop) begin
			rd_data <= mem[rd_ptr_q];
		end
	end

	// Advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (ctl.push) begin
				wr_ptr_q <= wr_ptr_nxt;
			end
			if (ctl.pop) begin
				rd_ptr_q <= rd_ptr_nxt;
			end
		end
	end
endmodule

// ===== tb/sv/uart_status_checker.sv =====
`timescale 1ns / 100ps

module uart_status_checker #(
	parameter int DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  logic                item_ready,
	input  u8n1f_pkg::item_t    item_data,
	input  logic                result_valid,
	input  logic                result_ready,
	input  u8n1f_pkg::result_t  result_data,
	input  logic                cfg_wr_en,
	input  logic [15:0]         cfg_wr_data,
	output int                  fail_count,
	output int                  pending
);
	import u8n1f_pkg::*;

	// Shadow copy of the UART state and its period register
	logic [15:0] bit_ticks;
	logic [7:0]  tx_mem [DEPTH];
	logic [7:0]  rx_mem [DEPTH];
	int          tx_wp, tx_rp, rx_wp, rx_rp;
	logic [8:0]  tx_sr;
	logic [3:0]  tx_left;
	logic        tx_on;
	logic [15:0] tx_cnt;
	logic        tx_lvl;
	logic [7:0]  rx_sr;
	logic [3:0]  rx_taken;
	logic        rx_on;
	logic [16:0] rx_cnt;
	logic        rx_last;

	// Status words still owed by the block, oldest first
	result_t status_due [$];

	function automatic logic [16:0] bit_period();
		return (bit_ticks == 16'd0) ? 17'd1 : {1'b0, bit_ticks};
	endfunction

	// Apply one item to the shadow state and return the status it reports
	function automatic result_t uart_advance(input item_t it);
		result_t st;
		int      nxt;
		st = '0;
		case (it.op)
			OP_TICK: begin
				// Advance the transmit bit timer, drive the next frame bit on expiry
				if (tx_on) begin
					if (tx_cnt > 16'd1) begin
						tx_cnt--;
					end else begin
						tx_cnt = 16'(bit_period());
						if (tx_left != 4'd0) begin
							tx_lvl  = tx_sr[0];
							tx_sr   = tx_sr >> 1;
							tx_left--;
						end else if (tx_wp != tx_rp) begin
							tx_sr   = {1'b1, tx_mem[tx_rp]};
							tx_rp   = (tx_rp + 1) % DEPTH;
							tx_left = 4'd9;
							tx_lvl  = 1'b0;
						end else begin
							tx_on  = 1'b0;
							tx_lvl = 1'b1;
						end
					end
				end
				// Sample the receive line, or watch for a start edge while idle
				if (rx_on) begin
					if (rx_cnt > 17'd1) begin
						rx_cnt--;
					end else begin
						rx_cnt = bit_period();
						if (rx_taken < 4'd8) begin
							rx_sr = {it.rx_level, rx_sr[7:1]};
							rx_taken++;
						end else begin
							nxt = (rx_wp + 1) % DEPTH;
							if (nxt != rx_rp) begin
								rx_mem[rx_wp] = rx_sr;
								rx_wp = nxt;
							end else begin
								st.rx_dropped = 1'b1;
							end
							rx_on = 1'b0;
						end
					end
				end else if (rx_last && !it.rx_level) begin
					rx_on    = 1'b1;
					rx_cnt   = bit_period() + (bit_period() >> 1);
					rx_sr    = 8'd0;
					rx_taken = 4'd0;
				end
				rx_last = it.rx_level;
			end
			OP_PUSH: begin
				// Queue the byte unless the ring is full; start an idle transmitter
				nxt = (tx_wp + 1) % DEPTH;
				if (nxt != tx_rp) begin
					tx_mem[tx_wp] = it.tx_byte;
					tx_wp = nxt;
					st.push_accepted = 1'b1;
					if (!tx_on) begin
						tx_on  = 1'b1;
						tx_cnt = 16'(bit_period());
					end
				end
			end
			OP_POP: begin
				if (rx_wp != rx_rp) begin
					st.rx_data       = rx_mem[rx_rp];
					st.rx_data_valid = 1'b1;
					rx_rp = (rx_rp + 1) % DEPTH;
				end
			end
			default: begin
			end
		endcase
		st.tx_line  = tx_lvl;
		st.rx_count = COUNT_W'((rx_wp + DEPTH - rx_rp) % DEPTH);
		st.tx_count = COUNT_W'((tx_wp + DEPTH - tx_rp) % DEPTH);
		return st;
	endfunction

	task automatic report_mismatch(input string msg);
		fail_count++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	// Track config writes, compare each result transfer, predict each item transfer
	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			fail_count = 0;
			bit_ticks = 16'd208;
			tx_wp     = 0;
			tx_rp     = 0;
			rx_wp     = 0;
			rx_rp     = 0;
			tx_sr     = '0;
			tx_left   = '0;
			tx_on     = 1'b0;
			tx_cnt    = '0;
			tx_lvl    = 1'b1;
			rx_sr     = '0;
			rx_taken  = '0;
			rx_on     = 1'b0;
			rx_cnt    = '0;
			rx_last   = 1'b1;
			status_due.delete();
		end else begin
			if (cfg_wr_en)
				bit_ticks = cfg_wr_data;
			if (result_valid && result_ready) begin
				if (status_due.size() == 0) begin
					report_mismatch("result transfer with no item outstanding");
				end else begin
					want = status_due.pop_front();
					check_field("tx_line", 8'(result_data.tx_line), 8'(want.tx_line));
					check_field("rx_data", result_data.rx_data, want.rx_data);
					check_field("rx_data_valid", 8'(result_data.rx_data_valid),
						8'(want.rx_data_valid));
					check_field("rx_count", 8'(result_data.rx_count), 8'(want.rx_count));
					check_field("tx_count", 8'(result_data.tx_count), 8'(want.tx_count));
					check_field("push_accepted", 8'(result_data.push_accepted),
						8'(want.push_accepted));
					check_field("rx_dropped", 8'(result_data.rx_dropped),
						8'(want.rx_dropped));
				end
			end
			if (item_valid && item_ready)
				status_due.push_back(uart_advance(item_data));
		end
		pending = status_due.size();
	end

endmodule

// ===== tb/sv/uart_8n1_with_fifos_core_test.sv =====
`timescale 1ns / 100ps

module uart_8n1_with_fifos_core_test;
	import u8n1f_pkg::*;

	localparam int FIFO_DEPTH  = 64;
	localparam int QUIET_LIMIT = 1000;
	localparam int MIXED_ITEMS = 30;
	localparam int FILL_FRAMES = FIFO_DEPTH + 2;

	typedef enum int {
		FLOW_FREE,
		FLOW_SRC_SLOW,
		FLOW_SNK_SLOW,
		FLOW_BOTH_LIGHT
	} flow_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;
	flow_t       flow;
	int          period_now;
	int          items_sent = 0;
	int          quiet = 0;
	int          fail_count;
	int          pending;

	u8n1f_chan #(.T(item_t))   item_ch ();
	u8n1f_chan #(.T(result_t)) result_ch ();

	uart_8n1_with_fifos_core #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_ch),
		.result     (result_ch),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	uart_status_checker #(
		.DEPTH(FIFO_DEPTH)
	) u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_ch.valid),
		.item_ready  (item_ch.ready),
		.item_data   (item_ch.data),
		.result_valid(result_ch.valid),
		.result_ready(result_ch.ready),
		.result_data (result_ch.data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	always #5 clk = ~clk;

	function automatic bit chance(input int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	// Stall the result side according to the current flow mode
	always @(negedge clk) begin
		result_ch.ready <= !chance((flow == FLOW_SNK_SLOW) ? 77 :
			(flow == FLOW_BOTH_LIGHT) ? 7 : 0);
	end

	// Abort when no transfer happens for too long
	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) ||
				(result_ch.valid && result_ch.ready)) begin
			quiet = 0;
		end else begin
			quiet++;
		end
		if (quiet >= QUIET_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic item_t make_item(input op_t op, input logic [7:0] data_byte,
			input logic level);
		item_t it;
		it.op       = op;
		it.tx_byte  = data_byte;
		it.rx_level = level;
		return it;
	endfunction

	// Offer one item, with random source gaps, and hold it until the transfer
	task automatic send_item(input item_t it);
		@(negedge clk);
		while (chance((flow == FLOW_SRC_SLOW) ? 77 : (flow == FLOW_BOTH_LIGHT) ? 7 : 0)) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data  <= it;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		if (it.op != OP_NOP)
			items_sent++;
	endtask

	task automatic send_tick(input logic level);
		send_item(make_item(OP_TICK, 8'($urandom), level));
	endtask

	// Slip a push, pop or no-op in between ticks now and then
	task automatic maybe_side_item(input int pop_pct);
		int pick;
		if (chance(15)) begin
			pick = $urandom_range(0, 99);
			if (pick < 50)
				send_item(make_item(OP_PUSH, 8'($urandom), 1'($urandom)));
			else if (pick < 50 + pop_pct)
				send_item(make_item(OP_POP, 8'($urandom), 1'($urandom)));
			else
				send_item(make_item(OP_NOP, 8'($urandom), 1'($urandom)));
		end
	endtask

	// Drive a receive frame; cut it short or break the stop bit for noise
	task automatic send_frame(input logic [7:0] data_byte, input int nbits,
			input logic stop_level, input int pop_pct);
		logic level;
		for (int k = 0; k < nbits; k++) begin
			level = (k == 0) ? 1'b0 : (k == 9) ? stop_level : data_byte[k-1];
			repeat (period_now) begin
				maybe_side_item(pop_pct);
				send_tick(level);
			end
		end
	endtask

	// Drain the block, then write the bit period
	task automatic set_bit_ticks(input logic [15:0] value);
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en  <= 1'b0;
		period_now = (value == 16'd0) ? 1 : int'(value);
	endtask

	// Mixed traffic: frames, push and pop bursts, line noise, broken frames
	task automatic run_mixed(input int budget);
		int stop_at;
		int pick;
		stop_at = items_sent + budget;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 55)
				send_frame(8'($urandom), 10, 1'b1, 40);
			else if (pick < 70)
				repeat ($urandom_range(1, 8))
					send_item(make_item(OP_PUSH, 8'($urandom), 1'($urandom)));
			else if (pick < 82)
				repeat ($urandom_range(1, 8))
					send_item(make_item(OP_POP, 8'($urandom), 1'($urandom)));
			else if (pick < 92)
				repeat ($urandom_range(1, 20))
					send_tick(1'($urandom));
			else
				send_frame(8'($urandom), $urandom_range(1, 10), 1'($urandom), 40);
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		cfg_wr_en       = 1'b0;
		cfg_wr_data     = 16'd0;
		item_ch.valid   = 1'b0;
		item_ch.data    = '0;
		flow            = FLOW_FREE;
		period_now      = 208;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset period: empty pop, ignored line on non-tick items, first pushes
		send_item(make_item(OP_POP, 8'h00, 1'b1));
		send_item(make_item(OP_NOP, 8'hFF, 1'b0));
		send_item(make_item(OP_PUSH, 8'h00, 1'b0));
		send_item(make_item(OP_PUSH, 8'hFF, 1'b1));
		send_tick(1'b1);
		send_tick(1'b1);
		send_item(make_item(OP_POP, 8'hA5, 1'b0));

		// Shortest period while the transmitter still counts the old one
		set_bit_ticks(16'd1);
		send_frame(8'h81, 10, 1'b1, 0);
		send_item(make_item(OP_POP, 8'h00, 1'b1));
		send_item(make_item(OP_POP, 8'h00, 1'b0));

		run_mixed(MIXED_ITEMS);

		// Zero period acts as one
		set_bit_ticks(16'd0);
		flow = FLOW_SRC_SLOW;
		run_mixed(MIXED_ITEMS);

		set_bit_ticks(16'd3);
		flow = FLOW_SNK_SLOW;
		run_mixed(MIXED_ITEMS);

		set_bit_ticks(16'd2);
		flow = FLOW_BOTH_LIGHT;
		run_mixed(MIXED_ITEMS);

		// Fill the transmit ring past full, then overrun the receive ring
		set_bit_ticks(16'd1);
		flow = FLOW_SNK_SLOW;
		repeat (FIFO_DEPTH)
			send_item(make_item(OP_PUSH, 8'($urandom), 1'($urandom)));
		repeat (FILL_FRAMES)
			send_frame(8'($urandom), 10, 1'b1, 0);
		repeat (FIFO_DEPTH + 1)
			send_item(make_item(OP_POP, 8'($urandom), 1'($urandom)));

		// Longest period: a few pushes and a long receive countdown
		set_bit_ticks(16'hFFFF);
		flow = FLOW_BOTH_LIGHT;
		repeat (4)
			send_item(make_item(OP_PUSH, 8'($urandom), 1'($urandom)));
		send_tick(1'b1);
		send_tick(1'b0);
		repeat (20)
			send_tick(1'($urandom));
		repeat (3)
			send_item(make_item(OP_POP, 8'($urandom), 1'($urandom)));

		// Drain and give the verdict
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (5) @(negedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/u8n1f_pkg.sv
rtl/u8n1f_chan.sv
rtl/u8n1f_ring.sv
rtl/uart_8n1_with_fifos_core.sv
tb/sv/uart_status_checker.sv
tb/sv/uart_8n1_with_fifos_core_test.sv
